// File: hdl/brpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpf_pkg
// Shared constants, types and helpers of the bas-relief pixel filter.
// ----------------------------------------------------------------------------
package brpf_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int SLOT_W        = 2;
  localparam int RELIEF_OFFSET = 1 << SLOT_W;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = 11;
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int DEPTH   = RELIEF_OFFSET * MAX_WIDTH;
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 4 * CHAN_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] a;
    logic [PIXEL_W-1:0] b;
    logic               frame_end;
  } brpf_entry_t;

  function automatic logic [COL_W-1:0] right_col(input logic [COL_W-1:0]  col,
                                                 input logic [SIZE_W-1:0] w);
    logic [SIZE_W-1:0] sum;
    logic [SIZE_W-1:0] lim;
    sum = {1'b0, col} + SIZE_W'(RELIEF_OFFSET);
    lim = w - SIZE_W'(1);
    return (sum > lim) ? lim[COL_W-1:0] : sum[COL_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] vmax);
    if (v == '0) begin
      return SIZE_W'(1);
    end
    return (v > vmax) ? vmax : v;
  endfunction

endpackage

// File: hdl/bas_relief_pixel_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_relief_pixel_filter_top
// Bas-relief filter on a raster stream of RGBA pixels.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  cfg      cfg_we_i                   cfg_index_i, cfg_data_i
//  in       in_valid_i / in_ready_o    opcode_i, red_i, green_i, blue_i, alpha_i
//  out      out_valid_o / out_ready_i  out_red_o .. out_alpha_o, frame_end_o
//
//  One word per cycle in and out unless stalled; a result passes the row store
//  read, queue and output register. The row store has one write and two read
//  ports, so a drain tick reads both neighbors in the same cycle.
//  Reset clears positions and sizes (1024 x 1024); the row store is not cleared.
//  A stalled output fills the four-entry queue, then input ready drops.
// ----------------------------------------------------------------------------
module bas_relief_pixel_filter_top import brpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [CHAN_W-1:0] red_i,
  input  logic [CHAN_W-1:0] green_i,
  input  logic [CHAN_W-1:0] blue_i,
  input  logic [CHAN_W-1:0] alpha_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAN_W-1:0] out_red_o,
  output logic [CHAN_W-1:0] out_green_o,
  output logic [CHAN_W-1:0] out_blue_o,
  output logic [CHAN_W-1:0] out_alpha_o,
  output logic              frame_end_o
);

  logic               push, pop, head_valid;
  brpf_entry_t        push_entry, head_entry;
  logic [QCNT_W-1:0]  q_count;
  logic [PIXEL_W-1:0] out_pixel;

  brpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .pixel_i      ({alpha_i, blue_i, green_i, red_i}),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  brpf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .count_o      (q_count)
  );

  brpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_pixel_o  (out_pixel),
    .frame_end_o  (frame_end_o)
  );

  assign out_red_o   = out_pixel[0*CHAN_W +: CHAN_W];
  assign out_green_o = out_pixel[1*CHAN_W +: CHAN_W];
  assign out_blue_o  = out_pixel[2*CHAN_W +: CHAN_W];
  assign out_alpha_o = out_pixel[3*CHAN_W +: CHAN_W];

endmodule

// File: hdl/brpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpf_front
// Accepts words, tracks raster position, keeps the row store and issues reads.
// ----------------------------------------------------------------------------
module brpf_front import brpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [SIZE_W-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [PIXEL_W-1:0]  pixel_i,
  input  logic [QCNT_W-1:0]   q_count_i,
  output logic                push_o,
  output brpf_entry_t         push_entry_o
);

  logic [SIZE_W-1:0] width_q, height_q;
  logic [SIZE_W-1:0] w_eff, h_eff, h_last;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic              draining_q, draining_d;
  logic              accept, is_pixel, emit;
  logic              col_wrap, row_wrap, out_col_wrap, out_last;
  logic [ADDR_W-1:0] addr_a, addr_b, addr_w;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rd_a_q, rd_b_q, s1_px_q;
  logic               s1_valid_q, s1_drain_q, s1_last_q;

  assign in_ready_o = ({1'b0, q_count_i} + (QCNT_W + 1)'(s1_valid_q))
                      < (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign is_pixel   = (opcode_i == OP_PIXEL);

  always_comb begin
    w_eff        = clamp_size(width_q, SIZE_W'(MAX_WIDTH));
    h_eff        = clamp_size(height_q, SIZE_W'(MAX_HEIGHT));
    h_last       = h_eff - SIZE_W'(1);
    col_wrap     = ({1'b0, in_col_q} + SIZE_W'(1)) >= w_eff;
    row_wrap     = ({1'b0, in_row_q} + SIZE_W'(1)) >= h_eff;
    out_col_wrap = ({1'b0, out_col_q} + SIZE_W'(1)) >= w_eff;
    out_last     = (({1'b0, out_row_q} + SIZE_W'(1)) >= h_eff) && out_col_wrap;
    addr_w       = {in_row_q[SLOT_W-1:0], in_col_q};
    addr_b       = {h_last[SLOT_W-1:0], out_col_q};
    if (is_pixel) begin
      addr_a = {in_row_q[SLOT_W-1:0], right_col(in_col_q, w_eff)};
      emit   = in_row_q >= ROW_W'(RELIEF_OFFSET);
    end else begin
      addr_a = {out_row_q[SLOT_W-1:0], right_col(out_col_q, w_eff)};
      emit   = draining_q;
    end
  end

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    draining_d = draining_q;
    if (accept) begin
      if (is_pixel) begin
        draining_d = 1'b0;
        if (col_wrap) begin
          in_col_d = '0;
          if (row_wrap) begin
            in_row_d   = '0;
            draining_d = 1'b1;
            out_col_d  = '0;
            out_row_d  = (h_eff > SIZE_W'(RELIEF_OFFSET))
                         ? ROW_W'(h_eff - SIZE_W'(RELIEF_OFFSET)) : '0;
          end else begin
            in_row_d = in_row_q + ROW_W'(1);
          end
        end else begin
          in_col_d = in_col_q + COL_W'(1);
        end
      end else if (draining_q) begin
        if (out_last) begin
          draining_d = 1'b0;
          out_row_d  = '0;
          out_col_d  = '0;
        end else if (out_col_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SIZE_W'(MAX_WIDTH);
      height_q   <= SIZE_W'(MAX_HEIGHT);
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      draining_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      draining_q <= draining_d;
      s1_valid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_drain_q <= !is_pixel;
      s1_px_q    <= pixel_i;
      s1_last_q  <= !is_pixel && out_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_a_q <= mem[addr_a];
      rd_b_q <= mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_pixel) begin
      mem[addr_w] <= pixel_i;
    end
  end

  assign push_o                 = s1_valid_q;
  assign push_entry_o.a         = rd_a_q;
  assign push_entry_o.b         = s1_drain_q ? rd_b_q : s1_px_q;
  assign push_entry_o.frame_end = s1_last_q;

endmodule

// File: hdl/brpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpf_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module brpf_queue import brpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  brpf_entry_t       push_entry_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output brpf_entry_t       head_entry_o,
  output logic [QCNT_W-1:0] count_o
);

  brpf_entry_t       slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign do_pop       = pop_i && (count_q != '0);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = slots_q[rd_ptr_q];
  assign count_o      = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: hdl/brpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brpf_back
// Computes the relief channels and holds the result word for the output.
// ----------------------------------------------------------------------------
module brpf_back import brpf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  brpf_entry_t       head_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PIXEL_W-1:0] out_pixel_o,
  output logic              frame_end_o
);

  logic                out_valid_q;
  logic [PIXEL_W-1:0]  pixel_q, pixel_d;
  logic                frame_end_q;
  logic [CHAN_W:0]     sum [4];

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = {1'b0, {CHAN_W{1'b1}}}
               - {1'b0, head_entry_i.a[k*CHAN_W +: CHAN_W]}
               + {1'b0, head_entry_i.b[k*CHAN_W +: CHAN_W]};
      pixel_d[k*CHAN_W +: CHAN_W] = sum[k][CHAN_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pixel_q     <= pixel_d;
      frame_end_q <= head_entry_i.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = pixel_q;
  assign frame_end_o = frame_end_q;

endmodule
